### hw/rtl/string_hash_table_quadratic_probe_macros.svh
// Assertion macros used by the string hash table controller.
`ifndef STRING_HASH_TABLE_QUADRATIC_PROBE_MACROS_SVH
`define STRING_HASH_TABLE_QUADRATIC_PROBE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHTQP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define SHTQP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### hw/rtl/shtqp_pkg.sv
// Package with the word types, codes and control structs of the string hash table.
package shtqp_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int KEY_BYTES_DEF  = 20;

  localparam logic [31:0] MULT_RESET = 32'd31;
  localparam logic [8:0]  SIZE_RESET = 9'd256;

  localparam logic CFG_MULT = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] key_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot;
  } out_word_t;

  typedef struct packed {
    logic       clr_wr;
    logic       hash_en;
    logic       key_clr;
    logic       div_start;
    logic       div_step;
    logic       probe_init;
    logic       probe_next;
    logic       meta_rd;
    logic       meta_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       byte_rd;
    logic       byte_wr;
    logic       res_ld;
    logic [2:0] res_status;
  } shtqp_cmd_t;

  typedef struct packed {
    logic too_long;
    logic div_last;
    logic clr_last;
    logic last_probe;
    logic slot_used;
    logic len_eq;
    logic byte_eq;
    logic idx_last;
    logic op_search;
  } shtqp_sts_t;

endpackage

### hw/rtl/shtqp_ctrl.sv
// Controller state machine that sequences hashing, division, probing and key transfers.
`include "string_hash_table_quadratic_probe_macros.svh"

module shtqp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output shtqp_pkg::shtqp_cmd_t cmd,
  input  shtqp_pkg::shtqp_sts_t sts
);
  import shtqp_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_HOME  = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_CRD   = 4'd7;
  localparam logic [3:0] S_CCHK  = 4'd8;
  localparam logic [3:0] S_KRD   = 4'd9;
  localparam logic [3:0] S_KWR   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [2:0] res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] miss_status;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign miss_status = sts.op_search ? ST_NOT_FOUND : ST_FULL;

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.res_status = res_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.hash_en = 1'b1;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.too_long) begin
          res_nxt   = ST_TOO_LONG;
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        cmd.probe_init = 1'b1;
        state_nxt      = S_PRD;
      end
      S_PRD: begin
        cmd.meta_rd = 1'b1;
        state_nxt   = S_PCHK;
      end
      S_PCHK: begin
        if (!sts.slot_used) begin
          if (sts.op_search) begin
            res_nxt   = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_KRD;
          end
        end else if (sts.op_search && sts.len_eq) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CRD;
        end else if (sts.last_probe) begin
          res_nxt   = miss_status;
          state_nxt = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PRD;
        end
      end
      S_CRD: begin
        cmd.byte_rd = 1'b1;
        state_nxt   = S_CCHK;
      end
      S_CCHK: begin
        if (!sts.byte_eq) begin
          if (sts.last_probe) begin
            res_nxt   = miss_status;
            state_nxt = S_DONE;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = S_PRD;
          end
        end else if (sts.idx_last) begin
          res_nxt   = ST_FOUND;
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CRD;
        end
      end
      S_KRD: begin
        cmd.byte_rd = 1'b1;
        state_nxt   = S_KWR;
      end
      S_KWR: begin
        cmd.byte_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.meta_wr = 1'b1;
          res_nxt     = ST_INSERTED;
          state_nxt   = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_KRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_ld  = 1'b1;
          cmd.key_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      res_r       <= ST_INSERTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SHTQP_ASSERT_IMP(a_no_overrun, cmd.res_ld, !out_valid_r || out_ready)
  `SHTQP_ASSERT_NXT(a_res_shown, cmd.res_ld, out_valid_r)
  `SHTQP_ASSERT_IMP(a_ins_only, cmd.meta_wr, !sts.op_search && !sts.too_long)

endmodule

### hw/rtl/shtqp_dp.sv
// Datapath with hash, divider, probe counters, key buffer and slot memories.
module shtqp_dp #(
  parameter int TABLE_SIZE = shtqp_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BYTES  = shtqp_pkg::KEY_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  shtqp_pkg::in_word_t   in_word,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_wdata,
  input  shtqp_pkg::shtqp_cmd_t cmd,
  output shtqp_pkg::shtqp_sts_t sts,
  output shtqp_pkg::out_word_t  out_word
);
  import shtqp_pkg::*;

  localparam int SW  = $clog2(TABLE_SIZE + 1);
  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int LW  = $clog2(KEY_BYTES + 2);
  localparam int KW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int BAW = $clog2(TABLE_SIZE * KEY_BYTES);
  localparam int CW  = (SW > 9) ? SW : 9;
  localparam int IW  = ((KW > LW) ? KW : LW) + 1;
  localparam int MW  = LW + 1;

  logic [31:0]   mult_r;
  logic [8:0]    tsize_r;
  logic [31:0]   hash_r;
  logic [LW-1:0] klen_r;
  logic          op_r;
  logic [31:0]   dvd_r;
  logic [SW-1:0] rem_r;
  logic [4:0]    dcnt_r;
  logic [AW-1:0] p_r;
  logic [SW-1:0] c_r;
  logic [BAW-1:0] base_r;
  logic [KW-1:0] idx_r;
  logic [AW-1:0] clr_cnt_r;
  logic [MW-1:0] meta_q_r;
  logic [7:0]    kb_q_r;
  logic [7:0]    sb_q_r;
  out_word_t     out_r;

  logic [7:0]    kbuf [KEY_BYTES];
  logic [7:0]    smem [TABLE_SIZE*KEY_BYTES];
  logic [MW-1:0] meta_mem [TABLE_SIZE];

  logic [CW-1:0] ts_ext;
  logic [CW-1:0] size_c;
  logic [SW-1:0] size_w;
  logic [SW:0]   div_t;
  logic [SW:0]   psum;
  logic          meta_we;
  logic [AW-1:0] meta_wa;
  logic [MW-1:0] meta_wd;
  logic [BAW-1:0] saddr;

  assign ts_ext = CW'(tsize_r);
  assign size_c = (ts_ext == '0) ? CW'(1) :
                  (ts_ext > CW'(TABLE_SIZE)) ? CW'(TABLE_SIZE) : ts_ext;
  assign size_w = SW'(size_c);
  assign div_t  = {rem_r, dvd_r[31]};
  assign psum   = (SW+1)'(p_r) + (SW+1)'(c_r) + (SW+1)'(1);
  assign saddr  = base_r + BAW'(idx_r);

  assign meta_we = cmd.clr_wr | cmd.meta_wr;
  assign meta_wa = cmd.clr_wr ? clr_cnt_r : p_r;
  assign meta_wd = cmd.clr_wr ? '0 : {1'b1, klen_r};

  assign sts.too_long   = klen_r > LW'(KEY_BYTES);
  assign sts.div_last   = (dcnt_r == 5'd31);
  assign sts.clr_last   = (clr_cnt_r == AW'(TABLE_SIZE - 1));
  assign sts.last_probe = (c_r == size_w - SW'(1));
  assign sts.slot_used  = meta_q_r[LW];
  assign sts.len_eq     = (meta_q_r[LW-1:0] == klen_r);
  assign sts.byte_eq    = (kb_q_r == sb_q_r);
  assign sts.idx_last   = ((IW'(idx_r) + IW'(1)) == IW'(klen_r));
  assign sts.op_search  = op_r;
  assign out_word       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r    <= MULT_RESET;
      tsize_r   <= SIZE_RESET;
      hash_r    <= '0;
      klen_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MULT: mult_r  <= cfg_wdata;
          CFG_SIZE: tsize_r <= cfg_wdata[8:0];
          default:  mult_r  <= mult_r;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      priority if (cmd.key_clr) begin
        hash_r <= '0;
        klen_r <= '0;
      end else if (cmd.hash_en) begin
        hash_r <= 32'(hash_r * mult_r) + {24'd0, in_word.key_byte};
        if (klen_r <= LW'(KEY_BYTES)) begin
          klen_r <= klen_r + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_en) begin
      op_r <= in_word.operation;
      if (klen_r < LW'(KEY_BYTES)) begin
        kbuf[KW'(klen_r)] <= in_word.key_byte;
      end
    end
    if (cmd.div_start) begin
      dvd_r  <= hash_r;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[30:0], 1'b0};
      dcnt_r <= dcnt_r + 5'd1;
      if (div_t >= (SW+1)'(size_w)) begin
        rem_r <= SW'(div_t - (SW+1)'(size_w));
      end else begin
        rem_r <= SW'(div_t);
      end
    end
    if (cmd.probe_init) begin
      p_r <= AW'(rem_r);
      c_r <= '0;
    end else if (cmd.probe_next) begin
      c_r <= c_r + SW'(1);
      if (psum >= (SW+1)'(size_w)) begin
        p_r <= AW'(psum - (SW+1)'(size_w));
      end else begin
        p_r <= AW'(psum);
      end
    end
    if (cmd.meta_rd) begin
      base_r <= BAW'(BAW'(p_r) * BAW'(KEY_BYTES));
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + KW'(1);
    end
    if (cmd.res_ld) begin
      out_r.status <= cmd.res_status;
      if (cmd.res_status == ST_INSERTED || cmd.res_status == ST_FOUND) begin
        out_r.slot <= 8'(p_r);
      end else begin
        out_r.slot <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (cmd.meta_rd) begin
      meta_q_r <= meta_mem[p_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_rd) begin
      kb_q_r <= kbuf[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      smem[saddr] <= kb_q_r;
    end
    if (cmd.byte_rd) begin
      sb_q_r <= smem[saddr];
    end
  end

endmodule

### hw/rtl/string_hash_table_quadratic_probe.sv
// Top level of the string hash table with triangular probing.
//
//   channel   direction   handshake               word
//   in_       input       in_valid / in_ready     in_word (operation, key_byte, last_byte)
//   out_      output      out_valid / out_ready   out_word (status, slot)
//   cfg_      input       cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// A byte that is not the last is hashed as it is taken. A last byte adds a length check,
// the bit-serial remainder unit, loading the home slot, a slot read and check per probe,
// a byte read and a compare or copy per byte of a key, and the handover of the word.
// A key that is too long goes from the length check straight to the handover.
// After reset a pass clears the slot valid marks of all TABLE_SIZE slots, with in_ready low.
// A pending result waits in the output register; the next key's bytes are still taken.
module string_hash_table_quadratic_probe #(
  parameter int TABLE_SIZE = shtqp_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BYTES  = shtqp_pkg::KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  shtqp_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output shtqp_pkg::out_word_t out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import shtqp_pkg::*;

  shtqp_cmd_t cmd;
  shtqp_sts_t sts;

  assign cfg_ready = 1'b1;

  shtqp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_word.last_byte),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  shtqp_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BYTES  (KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word)
  );

endmodule
